// File: src/hsv_to_rgb_converter_defines.svh
// assertion macros shared by the converter rtl
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HSVC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define HSVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HSVC_ASSERT_IMP(label, clk, rst, ante, cons)
`define HSVC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: src/hsvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsvc_pkg;

   localparam int HueW    = 16;
   localparam int UnitW   = 17;
   localparam int ChanW   = 8;
   localparam int FracW   = 16;
   localparam int SectorW = 3;

   localparam int ReqDataW = ((HueW + 2 * UnitW + 7) / 8) * 8;
   localparam int RspDataW = ((3 * ChanW + 7) / 8) * 8;

   typedef logic [HueW-1:0]  hue_type;
   typedef logic [UnitW-1:0] unit_type;
   typedef logic [FracW-1:0] frac_type;
   typedef logic [ChanW-1:0] chan_type;

   // unit value one in 1.16
   localparam unit_type One = unit_type'(1) << FracW;

   // hue sectors, dominant channel pair
   typedef enum logic [SectorW-1:0] {
      SEC_RED_YELLOW     = 3'd0,
      SEC_YELLOW_GREEN   = 3'd1,
      SEC_GREEN_CYAN     = 3'd2,
      SEC_CYAN_BLUE      = 3'd3,
      SEC_BLUE_MAGENTA   = 3'd4,
      SEC_MAGENTA_RED    = 3'd5
   } sector_type;

   typedef struct packed {
      unit_type   chroma;
      unit_type   brightness;
      unit_type   weight;
      sector_type sector;
   } chroma_type;

   typedef struct packed {
      unit_type red;
      unit_type green;
      unit_type blue;
   } level_type;

   typedef struct packed {
      chan_type blue;
      chan_type green;
      chan_type red;
   } color_type;

endpackage

`default_nettype wire

// File: src/hsvc_chroma.sv
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_converter_defines.svh"

module hsvc_chroma (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire hsvc_pkg::hue_type   in_hue,
   input  wire hsvc_pkg::unit_type  in_saturation,
   input  wire hsvc_pkg::unit_type  in_brightness,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output hsvc_pkg::chroma_type     out_data
);
   import hsvc_pkg::*;

   // stage a: clamp, sector split, weight
   logic       a_valid_ff;
   unit_type   a_sat_ff, a_sat_in;
   unit_type   a_bri_ff, a_bri_in;
   unit_type   a_weight_ff, a_weight_in;
   sector_type a_sector_ff, a_sector_in;
   logic       a_ready;

   // stage b: chroma
   logic       b_valid_ff;
   chroma_type b_data_ff, b_data_in;
   logic       b_ready;

   logic [HueW+SectorW-1:0] hue6;
   logic [2*UnitW-1:0]      prod;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      a_sat_in = (in_saturation > One) ? One : in_saturation;
      a_bri_in = (in_brightness > One) ? One : in_brightness;
      hue6 = ({{SectorW{1'b0}}, in_hue} << 2) + ({{SectorW{1'b0}}, in_hue} << 1);
      a_sector_in = sector_type'(hue6[HueW+SectorW-1:FracW]);
      if (hue6[FracW]) begin
         a_weight_in = One - {1'b0, hue6[FracW-1:0]};
      end else begin
         a_weight_in = {1'b0, hue6[FracW-1:0]};
      end
   end

   always_comb begin
      prod = (2*UnitW)'(a_bri_ff) * (2*UnitW)'(a_sat_ff);
      b_data_in.chroma     = prod[UnitW+FracW-1:FracW];
      b_data_in.brightness = a_bri_ff;
      b_data_in.weight     = a_weight_ff;
      b_data_in.sector     = a_sector_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
      end
      if (a_ready && in_valid) begin
         a_sat_ff    <= a_sat_in;
         a_bri_ff    <= a_bri_in;
         a_weight_ff <= a_weight_in;
         a_sector_ff <= a_sector_in;
      end
      if (b_ready && a_valid_ff) b_data_ff <= b_data_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

   `HSVC_ASSERT_IMP(chroma_le_bri, clock, reset, b_valid_ff,
      b_data_ff.chroma <= b_data_ff.brightness)
   `HSVC_ASSERT_NEXT(stage_a_holds, clock, reset, a_valid_ff && !b_ready,
      a_valid_ff && $stable(a_sat_ff) && $stable(a_bri_ff) && $stable(a_weight_ff))

endmodule

`default_nettype wire

// File: src/hsvc_mix.sv
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_converter_defines.svh"

module hsvc_mix (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire hsvc_pkg::chroma_type in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output hsvc_pkg::level_type       out_data
);
   import hsvc_pkg::*;

   // stage c: secondary component and offset
   logic       c_valid_ff;
   unit_type   c_chroma_ff;
   unit_type   c_second_ff, c_second_in;
   unit_type   c_offset_ff, c_offset_in;
   sector_type c_sector_ff;
   logic       c_ready;

   // stage d: per channel level
   logic       d_valid_ff;
   level_type  d_level_ff, d_level_in;
   logic       d_ready;

   logic [2*UnitW-1:0] prod;
   unit_type           lvl_c, lvl_x, lvl_z;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   always_comb begin
      prod        = (2*UnitW)'(in_data.chroma) * (2*UnitW)'(in_data.weight);
      c_second_in = prod[UnitW+FracW-1:FracW];
      c_offset_in = in_data.brightness - in_data.chroma;
   end

   always_comb begin
      lvl_c = c_chroma_ff + c_offset_ff;
      lvl_x = c_second_ff + c_offset_ff;
      lvl_z = c_offset_ff;
      unique case (c_sector_ff)
         SEC_RED_YELLOW:   d_level_in = '{red: lvl_c, green: lvl_x, blue: lvl_z};
         SEC_YELLOW_GREEN: d_level_in = '{red: lvl_x, green: lvl_c, blue: lvl_z};
         SEC_GREEN_CYAN:   d_level_in = '{red: lvl_z, green: lvl_c, blue: lvl_x};
         SEC_CYAN_BLUE:    d_level_in = '{red: lvl_z, green: lvl_x, blue: lvl_c};
         SEC_BLUE_MAGENTA: d_level_in = '{red: lvl_x, green: lvl_z, blue: lvl_c};
         default:          d_level_in = '{red: lvl_c, green: lvl_z, blue: lvl_x};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (c_ready) c_valid_ff <= in_valid;
         if (d_ready) d_valid_ff <= c_valid_ff;
      end
      if (c_ready && in_valid) begin
         c_chroma_ff <= in_data.chroma;
         c_second_ff <= c_second_in;
         c_offset_ff <= c_offset_in;
         c_sector_ff <= in_data.sector;
      end
      if (d_ready && c_valid_ff) d_level_ff <= d_level_in;
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_level_ff;

   `HSVC_ASSERT_IMP(second_le_chroma, clock, reset, c_valid_ff, c_second_ff <= c_chroma_ff)
   `HSVC_ASSERT_IMP(level_in_range, clock, reset, d_valid_ff,
      d_level_ff.red <= One && d_level_ff.green <= One && d_level_ff.blue <= One)

endmodule

`default_nettype wire

// File: src/hsvc_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module hsvc_scale (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire hsvc_pkg::level_type in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output hsvc_pkg::color_type      out_data
);
   import hsvc_pkg::*;

   localparam int ProdW = UnitW + ChanW + 1;

   logic      e_valid_ff;
   color_type e_color_ff, e_color_in;

   // level * 255 as (level << 8) - level, keep bits 23:16
   function automatic chan_type to_chan(input unit_type lvl);
      logic [ProdW-1:0] p;
      p = ({{(ChanW+1){1'b0}}, lvl} << ChanW) - {{(ChanW+1){1'b0}}, lvl};
      return p[FracW+ChanW-1:FracW];
   endfunction

   assign in_ready = !e_valid_ff || out_ready;

   always_comb begin
      e_color_in.red   = to_chan(in_data.red);
      e_color_in.green = to_chan(in_data.green);
      e_color_in.blue  = to_chan(in_data.blue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (in_ready) begin
         e_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) e_color_ff <= e_color_in;
   end

   assign out_valid = e_valid_ff;
   assign out_data  = e_color_ff;

endmodule

`default_nettype wire

// File: src/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// hsv to rgb pixel converter: takes one hue, saturation, brightness beat and
// returns one 8-bit red, green, blue beat. hue is a 0.16 fraction of the full
// circle, saturation and brightness are 1.16 fractions where fields above one
// are clamped to one. one beat is accepted every cycle while the result side
// is not stalled, through five register stages (clamp and sector split,
// chroma multiply, secondary multiply, channel select, scaling by 255), each
// holding at most one 17x17 multiply. a stall on the result side backs up
// stage by stage, so empty stages still take beats.
module hsv_to_rgb_converter (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input beat
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // hue [15:0], saturation [32:16], brightness [49:33], zero fill above
   input  wire logic [hsvc_pkg::ReqDataW-1:0]   req_tdata,
   // result beat
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // red [7:0], green [15:8], blue [23:16]
   output logic [hsvc_pkg::RspDataW-1:0]        rsp_tdata
);
   import hsvc_pkg::*;

   // fields out of the input beat
   hue_type  req_hue;
   unit_type req_saturation;
   unit_type req_brightness;

   assign req_hue        = req_tdata[HueW-1:0];
   assign req_saturation = req_tdata[HueW+UnitW-1:HueW];
   assign req_brightness = req_tdata[HueW+2*UnitW-1:HueW+UnitW];

   // chroma to mix
   logic       chr_valid;
   logic       chr_ready;
   chroma_type chr_data;

   // mix to scale
   logic       mix_valid;
   logic       mix_ready;
   level_type  mix_data;

   // scaled color
   color_type  color;

   // stages a and b: clamp, sector, chroma
   hsvc_chroma u_chroma (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_hue        (req_hue),
      .in_saturation (req_saturation),
      .in_brightness (req_brightness),
      .out_valid     (chr_valid),
      .out_ready     (chr_ready),
      .out_data      (chr_data)
   );

   // stages c and d: secondary component, offset, sector routing
   hsvc_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chr_valid),
      .in_ready  (chr_ready),
      .in_data   (chr_data),
      .out_valid (mix_valid),
      .out_ready (mix_ready),
      .out_data  (mix_data)
   );

   // stage e: scale by 255, output register
   hsvc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_ready  (mix_ready),
      .in_data   (mix_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (color)
   );

   // pack result beat, zero fill above the three channels
   assign rsp_tdata = RspDataW'({color.blue, color.green, color.red});

endmodule

`default_nettype wire
